### sv/complex_arithmetic_unit_assert.svh
// Assertion macros used by the checker file of the complex ALU.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Whenever ant holds at a clock edge, cons must hold at the same edge.
`define CAU_ASSERT_IMPLY(label, clk, rst_n, ant, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
		else $error("complex ALU check failed");

// The condition must never hold at a clock edge out of reset.
`define CAU_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("complex ALU check failed");

`endif

### sv/cau_pkg.sv
// Package of the complex ALU: opcodes and shared constants.
`timescale 1ns / 1ps
package cau_pkg;

	localparam int FRAC_BITS_DEF = 16;
	// Quotient bits resolved by the divider, one per stage (bits 32 down to 0).
	localparam int QBITS = 33;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_MUL   = 3'd2,
		OP_CDIV  = 3'd3,
		OP_CONJ  = 3'd4,
		OP_EQ    = 3'd5,
		OP_MAGSQ = 3'd6,
		OP_DIVR  = 3'd7
	} op_t;

endpackage

### sv/complex_arithmetic_unit.sv
// Top level of the pipelined complex-number ALU on signed fixed-point operands.
`timescale 1ns / 1ps
// Usage:
//   Drive opcode, a_real, a_imag, b_real, b_imag and raise start for one cycle
//   per beat; a beat is taken at every rising edge with start high and busy low.
//   busy is always low: the pipeline takes a new beat every cycle.
//   Each beat yields exactly one result beat, shown for one cycle with done
//   high, in the order the beats entered.
// Every opcode passes through every stage. Throughput is one beat per cycle.
// What sets the depth: one input stage, one stage of six 32x32 multipliers,
//   one stage of wide sums, one stage of rounding and divider setup, then 33
//   restoring-divide stages (one quotient bit each, bits 32 down to 0), and a
//   final stage that rounds the quotient and saturates into the output
//   registers. Non-divide opcodes ride the divider stages unchanged.
// Reset: arst_n clears all valid bits at once; beats in flight are dropped and
//   done stays low until new beats come out. Payload registers are not reset.
// The receiver cannot stall: results are never held back.
module complex_arithmetic_unit #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] a_real,
	input  logic signed [31:0] a_imag,
	input  logic signed [31:0] b_real,
	input  logic signed [31:0] b_imag,
	output logic               done,
	output logic signed [31:0] result_real,
	output logic signed [31:0] result_imag,
	output logic               is_equal,
	output logic               divide_by_zero,
	output logic               overflow
);

	localparam int QB = cau_pkg::QBITS;
	localparam int QW = QB + 1;            // quotient or clamped magnitude
	localparam int NW = 64 + FRAC_BITS;    // dividend after the fraction shift
	localparam int CW = NW + QB;           // compare width for shifted divisors

	assign busy = 1'b0;

	// ---------------- stage 1: input registers ----------------
	logic               v_s1;
	cau_pkg::op_t       op_s1;
	logic signed [31:0] ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		op_s1 <= cau_pkg::op_t'(opcode);
		ar_s1 <= a_real;
		ai_s1 <= a_imag;
		br_s1 <= b_real;
		bi_s1 <= b_imag;
	end

	// ---------------- stage 2: products and linear ops ----------------
	logic signed [31:0] mx0, my0, mx1, my1;
	logic signed [32:0] lin_re_c, lin_im_c;
	logic               v_s2;
	cau_pkg::op_t       op_s2;
	logic signed [63:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [32:0] lin_re_s2, lin_im_s2;
	logic               flip_s2, eq_s2, dz_s2;
	logic [31:0]        d7_s2;

	// Squared magnitude of a reuses the first two multipliers.
	always_comb begin
		if (op_s1 == cau_pkg::OP_MAGSQ) begin
			mx0 = ar_s1; my0 = ar_s1;
			mx1 = ai_s1; my1 = ai_s1;
		end else begin
			mx0 = ar_s1; my0 = br_s1;
			mx1 = ai_s1; my1 = bi_s1;
		end
	end

	always_comb begin
		case (op_s1)
			cau_pkg::OP_ADD: begin
				lin_re_c = 33'(ar_s1) + 33'(br_s1);
				lin_im_c = 33'(ai_s1) + 33'(bi_s1);
			end
			cau_pkg::OP_SUB: begin
				lin_re_c = 33'(ar_s1) - 33'(br_s1);
				lin_im_c = 33'(ai_s1) - 33'(bi_s1);
			end
			cau_pkg::OP_CONJ: begin
				lin_re_c = 33'(ar_s1);
				lin_im_c = -33'(ai_s1);
			end
			cau_pkg::OP_DIVR: begin
				lin_re_c = 33'(ar_s1);
				lin_im_c = 33'(ai_s1);
			end
			default: begin
				lin_re_c = '0;
				lin_im_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		op_s2     <= op_s1;
		p0_s2     <= 64'(mx0) * 64'(my0);
		p1_s2     <= 64'(mx1) * 64'(my1);
		p2_s2     <= 64'(ar_s1) * 64'(bi_s1);
		p3_s2     <= 64'(ai_s1) * 64'(br_s1);
		p4_s2     <= 64'(br_s1) * 64'(br_s1);
		p5_s2     <= 64'(bi_s1) * 64'(bi_s1);
		lin_re_s2 <= lin_re_c;
		lin_im_s2 <= lin_im_c;
		flip_s2   <= br_s1[31];
		d7_s2     <= br_s1[31] ? 32'(-br_s1) : 32'(br_s1);
		eq_s2     <= (op_s1 == cau_pkg::OP_EQ) && (ar_s1 == br_s1) && (ai_s1 == bi_s1);
		dz_s2     <= (op_s1 == cau_pkg::OP_DIVR) && (br_s1 == 32'sd0);
	end

	// ---------------- stage 3: sums, signs and magnitudes ----------------
	function automatic logic [63:0] abs66(input logic signed [65:0] s);
		logic signed [65:0] t;
		t = s[65] ? -s : s;
		return t[63:0];
	endfunction

	function automatic logic [63:0] abs33(input logic signed [32:0] s);
		logic signed [32:0] t;
		t = s[32] ? -s : s;
		return 64'($unsigned(t));
	endfunction

	logic signed [65:0] sm_re_c, sm_im_c, sd_re_c, sd_im_c;
	logic [63:0]        den_c;
	logic               neg_re_c, neg_im_c, rnd_c, div_c, dz_c;
	logic [63:0]        mag_re_c, mag_im_c, d_c;

	assign sm_re_c = 66'(p0_s2) - 66'(p1_s2);
	assign sm_im_c = 66'(p2_s2) + 66'(p3_s2);
	assign sd_re_c = 66'(p0_s2) + 66'(p1_s2);
	assign sd_im_c = 66'(p3_s2) - 66'(p2_s2);
	assign den_c   = p4_s2[63:0] + p5_s2[63:0];

	always_comb begin
		neg_re_c = 1'b0;
		neg_im_c = 1'b0;
		mag_re_c = '0;
		mag_im_c = '0;
		rnd_c    = 1'b0;
		div_c    = 1'b0;
		dz_c     = 1'b0;
		d_c      = 64'd1;
		case (op_s2)
			cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_CONJ: begin
				neg_re_c = lin_re_s2[32];
				neg_im_c = lin_im_s2[32];
				mag_re_c = abs33(lin_re_s2);
				mag_im_c = abs33(lin_im_s2);
			end
			cau_pkg::OP_MUL: begin
				neg_re_c = sm_re_c[65];
				neg_im_c = sm_im_c[65];
				mag_re_c = abs66(sm_re_c);
				mag_im_c = abs66(sm_im_c);
				rnd_c    = 1'b1;
			end
			cau_pkg::OP_CDIV: begin
				if (den_c == 64'd0) begin
					dz_c = 1'b1;
				end else begin
					neg_re_c = sd_re_c[65];
					neg_im_c = sd_im_c[65];
					mag_re_c = abs66(sd_re_c);
					mag_im_c = abs66(sd_im_c);
					div_c    = 1'b1;
					d_c      = den_c;
				end
			end
			cau_pkg::OP_MAGSQ: begin
				mag_re_c = abs66(sd_re_c);
				rnd_c    = 1'b1;
			end
			cau_pkg::OP_DIVR: begin
				if (dz_s2) begin
					dz_c = 1'b1;
				end else begin
					neg_re_c = lin_re_s2[32] ^ flip_s2;
					neg_im_c = lin_im_s2[32] ^ flip_s2;
					mag_re_c = abs33(lin_re_s2);
					mag_im_c = abs33(lin_im_s2);
					div_c    = 1'b1;
					d_c      = 64'(d7_s2);
				end
			end
			default: begin
			end
		endcase
	end

	logic        v_s3, neg_re_s3, neg_im_s3, rnd_s3, div_s3, dz_s3, eq_s3;
	logic [63:0] mag_re_s3, mag_im_s3, d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		neg_re_s3 <= neg_re_c;
		neg_im_s3 <= neg_im_c;
		mag_re_s3 <= mag_re_c;
		mag_im_s3 <= mag_im_c;
		rnd_s3    <= rnd_c;
		div_s3    <= div_c;
		dz_s3     <= dz_c;
		eq_s3     <= eq_s2;
		d_s3      <= d_c;
	end

	// ---------------- stage 4 and divider stages ----------------
	// Index k of the *_s4 arrays is pipeline stage 4+k.
	logic          v_s4      [0:QB];
	logic          neg_re_s4 [0:QB];
	logic          neg_im_s4 [0:QB];
	logic          div_s4    [0:QB];
	logic          dz_s4     [0:QB];
	logic          eq_s4     [0:QB];
	logic          big_re_s4 [0:QB];
	logic          big_im_s4 [0:QB];
	logic [NW-1:0] rem_re_s4 [0:QB];
	logic [NW-1:0] rem_im_s4 [0:QB];
	logic [QW-1:0] q_re_s4   [0:QB];
	logic [QW-1:0] q_im_s4   [0:QB];
	logic [63:0]   d_s4      [0:QB];

	localparam logic [64:0] HALF  = 65'(1) << (FRAC_BITS - 1);
	localparam logic [64:0] LIMIT = 65'(1) << QB;

	logic [64:0]   rv_re_c, rv_im_c;
	logic [QW-1:0] cl_re_c, cl_im_c;
	logic [NW-1:0] n_re_c, n_im_c;
	logic [CW-1:0] dtop_c;

	assign rv_re_c = rnd_s3 ? (({1'b0, mag_re_s3} + HALF) >> FRAC_BITS) : {1'b0, mag_re_s3};
	assign rv_im_c = rnd_s3 ? (({1'b0, mag_im_s3} + HALF) >> FRAC_BITS) : {1'b0, mag_im_s3};
	// Anything above 2^33 saturates anyway: clamp to keep the quotient lane narrow.
	assign cl_re_c = (rv_re_c > LIMIT) ? QW'(LIMIT) : rv_re_c[QW-1:0];
	assign cl_im_c = (rv_im_c > LIMIT) ? QW'(LIMIT) : rv_im_c[QW-1:0];
	assign n_re_c  = {mag_re_s3, {FRAC_BITS{1'b0}}};
	assign n_im_c  = {mag_im_s3, {FRAC_BITS{1'b0}}};
	assign dtop_c  = CW'(d_s3) << QB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4[0] <= 1'b0;
		else v_s4[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		neg_re_s4[0] <= neg_re_s3;
		neg_im_s4[0] <= neg_im_s3;
		div_s4[0]    <= div_s3;
		dz_s4[0]     <= dz_s3;
		eq_s4[0]     <= eq_s3;
		d_s4[0]      <= d_s3;
		if (div_s3) begin
			// Quotient of 2^33 or more always saturates: flag it up front.
			big_re_s4[0] <= CW'(n_re_c) >= dtop_c;
			big_im_s4[0] <= CW'(n_im_c) >= dtop_c;
			rem_re_s4[0] <= n_re_c;
			rem_im_s4[0] <= n_im_c;
			q_re_s4[0]   <= '0;
			q_im_s4[0]   <= '0;
		end else begin
			big_re_s4[0] <= 1'b0;
			big_im_s4[0] <= 1'b0;
			rem_re_s4[0] <= '0;
			rem_im_s4[0] <= '0;
			q_re_s4[0]   <= cl_re_c;
			q_im_s4[0]   <= cl_im_c;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_div
		localparam int SH = QB - k;
		logic [CW-1:0] dsh, rx_re, rx_im;
		logic          ge_re, ge_im;

		assign dsh   = CW'(d_s4[k-1]) << SH;
		assign rx_re = CW'(rem_re_s4[k-1]);
		assign rx_im = CW'(rem_im_s4[k-1]);
		assign ge_re = rx_re >= dsh;
		assign ge_im = rx_im >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s4[k] <= 1'b0;
			else v_s4[k] <= v_s4[k-1];
		end

		always_ff @(posedge clk) begin
			neg_re_s4[k] <= neg_re_s4[k-1];
			neg_im_s4[k] <= neg_im_s4[k-1];
			div_s4[k]    <= div_s4[k-1];
			dz_s4[k]     <= dz_s4[k-1];
			eq_s4[k]     <= eq_s4[k-1];
			big_re_s4[k] <= big_re_s4[k-1];
			big_im_s4[k] <= big_im_s4[k-1];
			d_s4[k]      <= d_s4[k-1];
			rem_re_s4[k] <= ge_re ? NW'(rx_re - dsh) : rem_re_s4[k-1];
			rem_im_s4[k] <= ge_im ? NW'(rx_im - dsh) : rem_im_s4[k-1];
			q_re_s4[k]   <= q_re_s4[k-1] | (QW'(ge_re) << SH);
			q_im_s4[k]   <= q_im_s4[k-1] | (QW'(ge_im) << SH);
		end
	end

	// ---------------- final stage: round quotient, saturate ----------------
	logic [CW-1:0] dfin_c;
	logic          up_re_c, up_im_c, sat_re_c, sat_im_c;
	logic [QW:0]   fm_re_c, fm_im_c;
	logic [31:0]   val_re_c, val_im_c;

	assign dfin_c  = CW'(d_s4[QB]);
	// Round half away from zero: bump when twice the remainder reaches the divisor.
	assign up_re_c = div_s4[QB] && (CW'({rem_re_s4[QB], 1'b0}) >= dfin_c);
	assign up_im_c = div_s4[QB] && (CW'({rem_im_s4[QB], 1'b0}) >= dfin_c);
	assign fm_re_c = (QW + 1)'(q_re_s4[QB]) + (QW + 1)'(up_re_c);
	assign fm_im_c = (QW + 1)'(q_im_s4[QB]) + (QW + 1)'(up_im_c);

	assign sat_re_c = big_re_s4[QB] ||
		(neg_re_s4[QB] ? (fm_re_c > (QW + 1)'(33'h080000000))
		               : (fm_re_c > (QW + 1)'(33'h07FFFFFFF)));
	assign sat_im_c = big_im_s4[QB] ||
		(neg_im_s4[QB] ? (fm_im_c > (QW + 1)'(33'h080000000))
		               : (fm_im_c > (QW + 1)'(33'h07FFFFFFF)));

	assign val_re_c = sat_re_c ? (neg_re_s4[QB] ? 32'h80000000 : 32'h7FFFFFFF)
		: (neg_re_s4[QB] ? (32'd0 - fm_re_c[31:0]) : fm_re_c[31:0]);
	assign val_im_c = sat_im_c ? (neg_im_s4[QB] ? 32'h80000000 : 32'h7FFFFFFF)
		: (neg_im_s4[QB] ? (32'd0 - fm_im_c[31:0]) : fm_im_c[31:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= v_s4[QB];
	end

	always_ff @(posedge clk) begin
		result_real    <= val_re_c;
		result_imag    <= val_im_c;
		is_equal       <= eq_s4[QB];
		divide_by_zero <= dz_s4[QB];
		overflow       <= sat_re_c || sat_im_c;
	end

endmodule

### sv/cau_checker.sv
// Port-level checker for the complex ALU and its bind to the top level.
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_assert.svh"

module cau_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               busy,
	input logic               done,
	input logic signed [31:0] result_real,
	input logic signed [31:0] result_imag,
	input logic               is_equal,
	input logic               divide_by_zero,
	input logic               overflow
);

	// The pipeline never pushes back on the sender.
	`CAU_ASSERT_NEVER(a_never_busy, clk, arst_n, busy)

	// A zero divisor gives zero parts and no saturation.
	`CAU_ASSERT_IMPLY(a_dz_zero, clk, arst_n, done && divide_by_zero, (result_real == 32'sd0) && (result_imag == 32'sd0) && !overflow && !is_equal)

	// A compare beat carries only its flag.
	`CAU_ASSERT_IMPLY(a_eq_zero, clk, arst_n, done && is_equal, (result_real == 32'sd0) && (result_imag == 32'sd0) && !overflow)

	// Overflow means some part sits at a saturation limit.
	`CAU_ASSERT_IMPLY(a_ovf_limit, clk, arst_n, done && overflow, (result_real == 32'h7FFFFFFF) || (result_real == 32'h80000000) || (result_imag == 32'h7FFFFFFF) || (result_imag == 32'h80000000))

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
